// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, reset by arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SAOT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define SAOT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/saot_pkg.sv =====
// ----------------------------------------------------------------------------
// saot_pkg
// Shared constants and types for the segment / box overlap test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package saot_pkg;

	// Default coordinate width (signed, 4 fraction bits).
	localparam int COORD_WIDTH_DEF = 18;

	// Per-stage advance strobes for the product / compare stages.
	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} saot_adv_t;

endpackage

// ===== sv/saot_cross_axis.sv =====
// ----------------------------------------------------------------------------
// saot_cross_axis
// Pipelined cross-axis test: |ta*db - tb*da| > 2*(ea*|db| + eb*|da|).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module saot_cross_axis
	import saot_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  saot_adv_t                     adv,
	input  logic signed [COORD_WIDTH+1:0] t_a,
	input  logic signed [COORD_WIDTH+1:0] t_b,
	input  logic signed [COORD_WIDTH:0]   d_a,
	input  logic signed [COORD_WIDTH:0]   d_b,
	input  logic        [COORD_WIDTH-1:0] m_a,
	input  logic        [COORD_WIDTH-1:0] m_b,
	input  logic        [COORD_WIDTH-2:0] e_a,
	input  logic        [COORD_WIDTH-2:0] e_b,
	output logic                          sep
);

	localparam int PW = 2 * COORD_WIDTH + 3;   // signed t*d product
	localparam int LW = PW + 1;                // difference
	localparam int QW = 2 * COORD_WIDTH - 1;   // e*|d| product
	localparam int RW = QW + 2;                // doubled sum

	logic signed [PW-1:0] p_ab_s3, p_ba_s3;
	logic        [QW-1:0] q_a_s3, q_b_s3;
	logic signed [LW-1:0] diff_s4;
	logic        [RW-1:0] rhs_s4, rhs_s5;
	logic        [LW-1:0] lm_s5;
	logic                 sep_s6;

	logic signed [PW-1:0] ta_x, tb_x, da_x, db_x;
	logic signed [LW-1:0] diff_d, diff_neg;
	logic        [QW:0]   qsum;

	assign ta_x = PW'(t_a);
	assign tb_x = PW'(t_b);
	assign da_x = PW'(d_a);
	assign db_x = PW'(d_b);

	assign diff_d   = LW'(p_ab_s3) - LW'(p_ba_s3);
	assign qsum     = (QW+1)'(q_a_s3) + (QW+1)'(q_b_s3);
	assign diff_neg = -diff_s4;

	// s3: four multiplies
	always_ff @(posedge clk) begin
		if (adv.s3) begin
			p_ab_s3 <= ta_x * db_x;
			p_ba_s3 <= tb_x * da_x;
			q_a_s3  <= QW'(e_a) * QW'(m_b);
			q_b_s3  <= QW'(e_b) * QW'(m_a);
		end
	end

	// s4: difference and doubled bound
	always_ff @(posedge clk) begin
		if (adv.s4) begin
			diff_s4 <= diff_d;
			rhs_s4  <= {qsum, 1'b0};
		end
	end

	// s5: magnitude
	always_ff @(posedge clk) begin
		if (adv.s5) begin
			lm_s5  <= diff_s4[LW-1] ? LW'(diff_neg) : LW'(diff_s4);
			rhs_s5 <= rhs_s4;
		end
	end

	// s6: compare
	always_ff @(posedge clk) begin
		if (adv.s6) begin
			sep_s6 <= lm_s5 > LW'(rhs_s5);
		end
	end

	assign sep = sep_s6;

endmodule

// ===== sv/segment_aabb_overlap_test_core.sv =====
// Segment / axis-aligned box overlap test, six-stage pipeline.
// Each accepted item beat passes through stages s1 to s6 to its result beat.
// Throughput: one item per cycle while result_stall is low; each stage holds
// one beat and moves it on whenever the stage after it is free or moving.
// Stalls back up stage by stage, so bubbles are squeezed out.
// Reset (arst_n low) clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// segment_aabb_overlap_test_core
// Separating-axis test of a segment against a box: three box axes plus three
// cross axes, in exact integer arithmetic on the unnormalized direction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_aabb_overlap_test_core
	import saot_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// item channel
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic signed [COORD_WIDTH-1:0] start_x,
	input  logic signed [COORD_WIDTH-1:0] start_y,
	input  logic signed [COORD_WIDTH-1:0] start_z,
	input  logic signed [COORD_WIDTH-1:0] end_x,
	input  logic signed [COORD_WIDTH-1:0] end_y,
	input  logic signed [COORD_WIDTH-1:0] end_z,
	input  logic signed [COORD_WIDTH-1:0] center_x,
	input  logic signed [COORD_WIDTH-1:0] center_y,
	input  logic signed [COORD_WIDTH-1:0] center_z,
	input  logic        [COORD_WIDTH-2:0] half_x,
	input  logic        [COORD_WIDTH-2:0] half_y,
	input  logic        [COORD_WIDTH-2:0] half_z,
	// result channel
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          hit
);

	localparam int TW = COORD_WIDTH + 2;   // T2 = 2c - s - f, signed
	localparam int DW = COORD_WIDTH + 1;   // d = f - s, signed
	localparam int MW = COORD_WIDTH;       // |d|
	localparam int EW = COORD_WIDTH - 1;   // half extent
	localparam int AW = TW - 1;            // |T2| and 2e + |d|

	// ---- stage valid bits and advance chain ----
	// A stage loads when it is empty or the stage after it moves on.
	logic      v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic      adv_s1, adv_s2;
	saot_adv_t adv;

	assign adv.s6 = !v_s6 || !result_stall;
	assign adv.s5 = !v_s5 || adv.s6;
	assign adv.s4 = !v_s4 || adv.s5;
	assign adv.s3 = !v_s3 || adv.s4;
	assign adv_s2 = !v_s2 || adv.s3;
	assign adv_s1 = !v_s1 || adv_s2;

	assign item_stall   = !adv_s1;
	assign result_valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= item_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv.s3) v_s3 <= v_s2;
			if (adv.s4) v_s4 <= v_s3;
			if (adv.s5) v_s5 <= v_s4;
			if (adv.s6) v_s6 <= v_s5;
		end
	end

	// ---- gather the item beat into per-axis arrays ----
	logic signed [COORD_WIDTH-1:0] s_in [3];
	logic signed [COORD_WIDTH-1:0] f_in [3];
	logic signed [COORD_WIDTH-1:0] c_in [3];
	logic        [EW-1:0]          e_in [3];

	assign s_in = '{start_x, start_y, start_z};
	assign f_in = '{end_x, end_y, end_z};
	assign c_in = '{center_x, center_y, center_z};
	assign e_in = '{half_x, half_y, half_z};

	// ---- s1: T2 and d ----
	logic signed [TW-1:0] t_s1 [3];
	logic signed [DW-1:0] d_s1 [3];
	logic        [EW-1:0] e_s1 [3];

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			for (int i = 0; i < 3; i++) begin
				t_s1[i] <= (TW'(c_in[i]) <<< 1) - TW'(s_in[i]) - TW'(f_in[i]);
				d_s1[i] <= DW'(f_in[i]) - DW'(s_in[i]);
				e_s1[i] <= e_in[i];
			end
		end
	end

	// ---- s2: magnitudes ----
	logic signed [TW-1:0] t_s2  [3];
	logic signed [DW-1:0] d_s2  [3];
	logic        [EW-1:0] e_s2  [3];
	logic        [AW-1:0] tm_s2 [3];
	logic        [MW-1:0] dm_s2 [3];
	logic signed [TW-1:0] t_neg [3];
	logic signed [DW-1:0] d_neg [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t_neg[i] = -t_s1[i];
			d_neg[i] = -d_s1[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			for (int i = 0; i < 3; i++) begin
				t_s2[i]  <= t_s1[i];
				d_s2[i]  <= d_s1[i];
				e_s2[i]  <= e_s1[i];
				tm_s2[i] <= t_s1[i][TW-1] ? t_neg[i][AW-1:0] : t_s1[i][AW-1:0];
				dm_s2[i] <= d_s1[i][DW-1] ? d_neg[i][MW-1:0] : d_s1[i][MW-1:0];
			end
		end
	end

	// ---- s3..s6: box-axis test result carried alongside the cross tests ----
	// Separated on box axis i when |T2.i| > 2*half.i + |d.i|; equality overlaps.
	logic [AW-1:0] bound [3];
	logic [2:0]    axis_far;
	logic          axis_s3, axis_s4, axis_s5, axis_s6;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			bound[i]    = AW'({e_s2[i], 1'b0}) + AW'(dm_s2[i]);
			axis_far[i] = tm_s2[i] > bound[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s3) axis_s3 <= |axis_far;
		if (adv.s4) axis_s4 <= axis_s3;
		if (adv.s5) axis_s5 <= axis_s4;
		if (adv.s6) axis_s6 <= axis_s5;
	end

	// ---- cross axes: box axis i crossed with d ----
	logic sep_x, sep_y, sep_z;

	saot_cross_axis #(.COORD_WIDTH(COORD_WIDTH)) u_cross_x (
		.clk (clk),
		.adv (adv),
		.t_a (t_s2[1]),  .t_b (t_s2[2]),
		.d_a (d_s2[1]),  .d_b (d_s2[2]),
		.m_a (dm_s2[1]), .m_b (dm_s2[2]),
		.e_a (e_s2[1]),  .e_b (e_s2[2]),
		.sep (sep_x)
	);

	saot_cross_axis #(.COORD_WIDTH(COORD_WIDTH)) u_cross_y (
		.clk (clk),
		.adv (adv),
		.t_a (t_s2[2]),  .t_b (t_s2[0]),
		.d_a (d_s2[2]),  .d_b (d_s2[0]),
		.m_a (dm_s2[2]), .m_b (dm_s2[0]),
		.e_a (e_s2[2]),  .e_b (e_s2[0]),
		.sep (sep_y)
	);

	saot_cross_axis #(.COORD_WIDTH(COORD_WIDTH)) u_cross_z (
		.clk (clk),
		.adv (adv),
		.t_a (t_s2[0]),  .t_b (t_s2[1]),
		.d_a (d_s2[0]),  .d_b (d_s2[1]),
		.m_a (dm_s2[0]), .m_b (dm_s2[1]),
		.e_a (e_s2[0]),  .e_b (e_s2[1]),
		.sep (sep_z)
	);

	// Overlap unless some axis separates. A zero-length segment zeroes every
	// cross term, leaving a closed point-in-box test.
	assign hit = !(axis_s6 || sep_x || sep_y || sep_z);

endmodule

// ===== sv/saot_checker.sv =====
// ----------------------------------------------------------------------------
// saot_checker
// Port-level checks on the overlap test core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module saot_checker (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_stall,
	input logic result_valid,
	input logic result_stall,
	input logic hit
);

	// A held result beat keeps its value.
	`SAOT_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid && $stable(hit))

	// Items back up only when the whole pipe is full behind a held result.
	`SAOT_ASSERT_IMP(a_stall_cause, item_stall, result_valid && result_stall)

	// With the result side free, an accepted item passes stages s1 to s6 and comes out as a result beat.
	`SAOT_ASSERT_NXT(a_latency, (item_valid && !item_stall) ##1 !result_stall ##1 !result_stall ##1 !result_stall ##1 !result_stall ##1 !result_stall, result_valid)

endmodule

bind segment_aabb_overlap_test_core saot_checker u_saot_checker (.*);
